// ===== sv/sus_pkg.sv =====
// Shared types and constants for the sorted unique key set.
// Used by every module of the block; depends on nothing.
package sus_pkg;

  localparam int unsigned SUS_CAPACITY   = 32;
  localparam int unsigned SUS_KEY_W      = 32;
  localparam int unsigned SUS_OCC_W      = 6;
  localparam int unsigned SUS_FIFO_DEPTH = 2;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_CLEAR
  } sus_op_e;

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [SUS_KEY_W-1:0] key_value;
  } sus_req_t;

  typedef struct packed {
    sus_op_e                     op;
    logic signed [SUS_KEY_W-1:0] key;
  } sus_cmd_t;

  typedef struct packed {
    logic [SUS_OCC_W-1:0]        occupancy;
    logic signed [SUS_KEY_W-1:0] element;
    logic                        element_valid;
    logic                        last;
    logic                        dropped_full;
  } sus_res_t;

endpackage

// ===== sv/sus_fifo.sv =====
// Small register queue of any packed item type.
// Depends on sus_pkg for the default depth.
module sus_fifo import sus_pkg::*; #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = SUS_FIFO_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/sus_front.sv =====
// Front end: accepts requests, decodes the request kind, queues commands.
// Depends on sus_pkg and sus_fifo.
module sus_front import sus_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sus_req_t req_i,
  output logic     full_o,
  output sus_cmd_t cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i
);

  sus_cmd_t cmd_in;
  logic     cmd_empty;

  always_comb begin
    cmd_in.key = req_i.key_value;
    unique case (req_i.func)
      FUNC_INSERT: cmd_in.op = OP_INSERT;
      FUNC_DELETE: cmd_in.op = OP_DELETE;
      default:     cmd_in.op = OP_CLEAR;  // clear and unused kinds empty the set
    endcase
  end

  sus_fifo #(
    .item_t (sus_cmd_t),
    .DEPTH  (SUS_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== sv/sus_back.sv =====
// Back end: sorted row of key cells updated in place, listing by rotation.
// Depends on sus_pkg and sus_fifo (result queue).
module sus_back import sus_pkg::*; #(
  parameter int unsigned CAPACITY = SUS_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sus_cmd_t cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_pop_o,
  output sus_res_t res_o,
  output logic     empty_o,
  input  logic     pop_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] One     = CntW'(1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } sus_state_e;

  sus_state_e state_q, state_d;

  logic signed [SUS_KEY_W-1:0] cell_q [CAPACITY];
  logic [CntW-1:0]             count_q, idx_q;
  logic                        drop_q;

  logic [CAPACITY-1:0] lt, eq;
  logic                found, is_full, cmd_take, do_ins, do_del, emit, do_rot, last;
  logic                out_full;
  sus_res_t            res_d;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    logic valid;
    assign valid = (CntW'(i) < count_q);
    assign lt[i] = valid && (cell_q[i] < cmd_i.key);
    assign eq[i] = valid && (cell_q[i] == cmd_i.key);
  end

  assign found    = |eq;
  assign is_full  = (count_q == FullCnt);
  assign cmd_take = (state_q == ST_IDLE) && cmd_valid_i;
  assign do_ins   = cmd_take && (cmd_i.op == OP_INSERT) && !found && !is_full;
  assign do_del   = cmd_take && (cmd_i.op == OP_DELETE) && found;
  assign emit     = (state_q == ST_EMIT) && !out_full;
  assign do_rot   = emit && (count_q != '0);
  assign last     = (count_q == '0) || (idx_q == count_q - One);
  assign cmd_pop_o = cmd_take;

  // Keys below the insert point hold; the rest shift up (insert) or down (delete).
  // Listing rotates the valid cells so the head cell carries the next key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [SUS_KEY_W-1:0] ins_v, del_v, rot_v;

    if (i == 0) begin : g_ins_first
      assign ins_v = lt[0] ? cell_q[0] : cmd_i.key;
    end else begin : g_ins_rest
      assign ins_v = lt[i] ? cell_q[i] : (lt[i-1] ? cmd_i.key : cell_q[i-1]);
    end

    if (i == CAPACITY - 1) begin : g_top
      assign del_v = cell_q[i];
      assign rot_v = (CntW'(i + 1) == count_q) ? cell_q[0] : cell_q[i];
    end else begin : g_mid
      assign del_v = lt[i] ? cell_q[i] : cell_q[i+1];
      assign rot_v = (CntW'(i + 1) < count_q)  ? cell_q[i+1] :
                     (CntW'(i + 1) == count_q) ? cell_q[0] : cell_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        cell_q[i] <= ins_v;
      end else if (do_del) begin
        cell_q[i] <= del_v;
      end else if (do_rot) begin
        cell_q[i] <= rot_v;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_take) state_d = ST_EMIT;
      ST_EMIT: if (emit && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_take) begin
        idx_q  <= '0;
        drop_q <= (cmd_i.op == OP_INSERT) && !found && is_full;
        if (cmd_i.op == OP_CLEAR) begin
          count_q <= '0;
        end else if (do_ins) begin
          count_q <= count_q + One;
        end else if (do_del) begin
          count_q <= count_q - One;
        end
      end else if (emit) begin
        idx_q <= idx_q + One;
      end
    end
  end

  always_comb begin
    res_d.occupancy     = SUS_OCC_W'(count_q);
    res_d.element       = (count_q == '0) ? '0 : cell_q[0];
    res_d.element_valid = (count_q != '0);
    res_d.last          = last;
    res_d.dropped_full  = drop_q;
  end

  sus_fifo #(
    .item_t (sus_res_t),
    .DEPTH  (SUS_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (res_d),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

endmodule

// ===== sv/sorted_unique_set.sv =====
// Top level of the sorted unique key set.
// Depends on sus_pkg, sus_front and sus_back.
//
// Requests enter through a queue port: an item is taken when push is high
// and full is low. func 0 inserts key_value, 1 deletes it, any other code
// empties the set. Duplicate inserts and deletes of absent keys leave the
// set unchanged; an insert into a full set is refused and every result of
// that run carries dropped_full.
// After each request the whole set is listed on res_o, smallest key first,
// one item per key with last on the final one; an empty set gives one item
// with element_valid low. A result waits while empty is low and is taken
// when pop is high.
// Timing: the back end updates the cell row when it takes a request, then
// lists the items; a request holds the back end until its last item is
// queued. The row rotates one key to its head per cycle while the result
// queue has room. Results reach res_o through the result queue.
// Two-item request and result queues decouple the sides; while pop stays
// low the listing pauses and requests back up until full rises.
// Reset empties the set and both queues.
module sorted_unique_set import sus_pkg::*; #(
  parameter int unsigned CAPACITY = SUS_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  sus_req_t req_i,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output sus_res_t res_o
);

  sus_cmd_t cmd;
  logic     cmd_valid, cmd_pop;

  sus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  sus_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// ===== sv/sus_checker.sv =====
// Port-level checks on the result side of the sorted unique key set.
// Depends on sus_pkg; bound to sorted_unique_set below.
module sus_checker import sus_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty_i,
  input logic     pop_i,
  input sus_res_t res_i
);

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i && !pop_i |=> !empty_i && $stable(res_i))
    else $error("result changed while stalled");

  // The empty-set item is a lone, final item with zero occupancy.
  a_empty_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i && !res_i.element_valid |->
      res_i.last && (res_i.occupancy == '0) && !res_i.dropped_full)
    else $error("malformed empty-set result");

  // A refused insert means the set was full, so keys are listed.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i && res_i.dropped_full |-> res_i.element_valid)
    else $error("dropped_full on an empty listing");

endmodule

bind sorted_unique_set sus_checker u_sus_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty_i (empty),
  .pop_i   (pop),
  .res_i   (res_o)
);

// ===== tb/tb_sorted_unique_set.sv =====
// Testbench for sorted_unique_set: drives insert, delete and clear requests and checks
// every listed key against a queue-based model of the sorted set.
// Depends on sus_pkg and the sorted_unique_set RTL; needs no other files.
module tb_sorted_unique_set;
  import sus_pkg::*;

  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * SUS_CAPACITY + 8;

  localparam logic signed [SUS_KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [SUS_KEY_W-1:0] KEY_MIN = 32'sh80000000;

  localparam sus_res_t EMPTY_RES = '{6'd0, 32'sd0, 1'b0, 1'b1, 1'b0};

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [SUS_KEY_W-1:0] key;
    logic                        typed;
    sus_res_t                    res;
  } dir_row_t;

  // Rows with typed set carry the single listing item they must produce.
  localparam dir_row_t DIR_ROWS [20] = '{
    '{FUNC_DELETE, 32'sd0,         1'b1, EMPTY_RES},
    '{FUNC_INSERT, KEY_MAX,        1'b1, '{6'd1, KEY_MAX, 1'b1, 1'b1, 1'b0}},
    '{FUNC_INSERT, KEY_MIN,        1'b0, '0},
    '{FUNC_INSERT, 32'sd0,         1'b0, '0},
    '{FUNC_INSERT, -32'sd1,        1'b0, '0},
    '{FUNC_INSERT, 32'sd0,         1'b0, '0},
    '{FUNC_INSERT, KEY_MAX,        1'b0, '0},
    '{FUNC_DELETE, 32'sd5,         1'b0, '0},
    '{FUNC_DELETE, KEY_MIN,        1'b0, '0},
    '{FUNC_DELETE, KEY_MAX,        1'b0, '0},
    '{FUNC_CLEAR,  32'sh12345678,  1'b1, EMPTY_RES},
    '{FUNC_INSERT, 32'sd1,         1'b1, '{6'd1, 32'sd1, 1'b1, 1'b1, 1'b0}},
    '{FUNC_DELETE, 32'sd1,         1'b1, EMPTY_RES},
    '{FUNC_INSERT, KEY_MIN,        1'b1, '{6'd1, KEY_MIN, 1'b1, 1'b1, 1'b0}},
    '{FUNC_UNUSED, -32'sd1,        1'b1, EMPTY_RES},
    '{FUNC_INSERT, 32'sh55555555,  1'b0, '0},
    '{FUNC_INSERT, 32'shaaaaaaaa,  1'b0, '0},
    '{FUNC_INSERT, 32'sd2,         1'b0, '0},
    '{FUNC_DELETE, 32'shaaaaaaaa,  1'b0, '0},
    '{FUNC_CLEAR,  32'sd0,         1'b0, '0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  sus_req_t req_i;
  logic     full;
  logic     empty;
  logic     pop;
  sus_res_t res_o;

  logic signed [SUS_KEY_W-1:0] held_keys[$];
  sus_res_t                    listing_q[$];
  int unsigned                 mismatch_cnt;
  int unsigned                 accepted_cnt;
  int unsigned                 burst_left;
  bit                          hold_req;

  sorted_unique_set i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .req_i  (req_i),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // first position whose key is not below k
  function automatic int find_slot(logic signed [SUS_KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < held_keys.size() && held_keys[i] < k) i++;
    return i;
  endfunction

  function automatic bit set_holds(logic signed [SUS_KEY_W-1:0] k);
    int p;
    p = find_slot(k);
    return p < held_keys.size() && held_keys[p] == k;
  endfunction

  task automatic predict_listing(sus_req_t r, logic typed, sus_res_t typed_res);
    int       p;
    bit       refused;
    sus_res_t res;
    refused = 1'b0;
    p = find_slot(r.key_value);
    case (r.func)
      FUNC_INSERT: begin
        if (!set_holds(r.key_value)) begin
          if (held_keys.size() >= SUS_CAPACITY) refused = 1'b1;
          else held_keys.insert(p, r.key_value);
        end
      end
      FUNC_DELETE: begin
        if (set_holds(r.key_value)) held_keys.delete(p);
      end
      default: held_keys.delete();
    endcase
    if (typed) begin
      listing_q.push_back(typed_res);
    end else if (held_keys.size() == 0) begin
      res = EMPTY_RES;
      res.dropped_full = refused;
      listing_q.push_back(res);
    end else begin
      for (int i = 0; i < held_keys.size(); i++) begin
        res.occupancy     = SUS_OCC_W'(held_keys.size());
        res.element       = held_keys[i];
        res.element_valid = 1'b1;
        res.last          = (i == held_keys.size() - 1);
        res.dropped_full  = refused;
        listing_q.push_back(res);
      end
    end
  endtask

  // Offer one request, idling first when the current burst is used up.
  task automatic send_req(sus_req_t r, logic typed, sus_res_t typed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      push <= 1'b0;
      repeat (gap) begin
        req_i.func      <= 2'($urandom_range(0, 3));
        req_i.key_value <= $urandom;
        @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    burst_left--;
    accepted_cnt++;
    predict_listing(r, typed, typed_res);
  endtask

  task automatic send_op(logic [1:0] f, logic signed [SUS_KEY_W-1:0] k);
    sus_req_t r;
    r.func      = f;
    r.key_value = k;
    send_req(r, 1'b0, '0);
  endtask

  function automatic logic signed [SUS_KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (held_keys.size() != 0) return held_keys[$urandom_range(0, held_keys.size() - 1)];
      end
      4, 5, 6: return $urandom_range(0, 15) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: ;
    endcase
    return $urandom;
  endfunction

  // Clear, fill up to capacity, then push against the limit.
  task automatic fill_set();
    logic signed [SUS_KEY_W-1:0] k;
    send_op($urandom_range(0, 1) ? FUNC_CLEAR : FUNC_UNUSED, pick_key());
    while (held_keys.size() < SUS_CAPACITY) send_op(FUNC_INSERT, pick_key());
    repeat ($urandom_range(2, 4)) begin
      do k = $urandom; while (set_holds(k));
      send_op(FUNC_INSERT, k);
    end
    // a duplicate into a full set is not a refusal
    send_op(FUNC_INSERT, held_keys[$urandom_range(0, SUS_CAPACITY - 1)]);
    send_op(FUNC_DELETE, held_keys[$urandom_range(0, SUS_CAPACITY - 1)]);
    send_op(FUNC_INSERT, $urandom_range(0, 1) ? KEY_MAX : KEY_MIN);
    send_op(FUNC_INSERT, $urandom_range(0, 1) ? KEY_MIN : KEY_MAX);
  endtask

  initial begin
    sus_req_t r;
    int unsigned pick;
    mismatch_cnt = 0;
    accepted_cnt = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    req_i        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      r.func      = DIR_ROWS[i].func;
      r.key_value = DIR_ROWS[i].key;
      send_req(r, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    // stall the receiver while the set fills so that requests back up
    hold_req = 1'b1;
    accepted_cnt = 0;
    fill_set();
    while (accepted_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: fill_set();
        8: begin
          repeat ($urandom_range(1, 5)) send_op(2'($urandom_range(0, 3)), $urandom);
        end
        9: begin
          while (held_keys.size() != 0) begin
            if ($urandom_range(0, 3) == 0) send_op(FUNC_DELETE, pick_key());
            else send_op(FUNC_DELETE, held_keys[$urandom_range(0, held_keys.size() - 1)]);
          end
        end
        default: begin
          repeat ($urandom_range(10, 30)) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) send_op(FUNC_INSERT, pick_key());
            else if (pick < 18) send_op(FUNC_DELETE, pick_key());
            else if (pick == 18) send_op(FUNC_CLEAR, pick_key());
            else send_op(FUNC_UNUSED, pick_key());
          end
        end
      endcase
    end
    push <= 1'b0;

    wait (listing_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: repeat a random pop pattern, with one long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    logic [5:0]  phase;
    logic [15:0] pop_pattern;
    hold_left   = 0;
    hold_taken  = 1'b0;
    phase       = '0;
    pop_pattern = '1;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (phase == 0) begin
          pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h1111);
        end
        pop <= pop_pattern[phase[3:0]];
        phase++;
      end
    end
  end

  always @(posedge clk_i) begin
    sus_res_t want;
    if (rst_ni && pop && !empty) begin
      if (listing_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h", res_o));
      end else begin
        want = listing_q.pop_front();
        if (res_o.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d", res_o.occupancy, want.occupancy));
        if (res_o.element !== want.element)
          report_mismatch($sformatf("element %0d, want %0d", res_o.element, want.element));
        if (res_o.element_valid !== want.element_valid)
          report_mismatch($sformatf("element_valid %b, want %b",
                                    res_o.element_valid, want.element_valid));
        if (res_o.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", res_o.last, want.last));
        if (res_o.dropped_full !== want.dropped_full)
          report_mismatch($sformatf("dropped_full %b, want %b",
                                    res_o.dropped_full, want.dropped_full));
      end
    end
  end

endmodule

// ===== filelist.f =====
sv/sus_pkg.sv
sv/sus_fifo.sv
sv/sus_front.sv
sv/sus_back.sv
sv/sorted_unique_set.sv
sv/sus_checker.sv
tb/tb_sorted_unique_set.sv
